### design/fbc_pkg.sv
package fbc_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int PLANE_COUNT   = 6;
    localparam int MATRIX_SIZE   = 4;
    localparam int AXES          = 3;

    localparam int PLANE_W  = $clog2(PLANE_COUNT);
    localparam int SUB_W    = $clog2(MATRIX_SIZE);
    localparam int OPND_W   = VALUE_WIDTH + 1;
    localparam int PROD_W   = 2 * OPND_W;
    localparam int SUMSQ_W  = 2 * VALUE_WIDTH;
    localparam int LEN_W    = VALUE_WIDTH;
    localparam int REM_W    = LEN_W + 3;
    localparam int NUM_W    = VALUE_WIDTH + FRACTION_BITS;
    localparam int ACC_W    = PROD_W + 2;
    localparam int STEP_W   = $clog2(NUM_W);

    localparam int SQRT_STEPS = SUMSQ_W / 2;
    localparam int DIV_STEPS  = NUM_W;

    localparam logic [PLANE_W-1:0] LAST_PLANE = PLANE_W'(PLANE_COUNT - 1);
    localparam logic [SUB_W-1:0]   LAST_COMP  = SUB_W'(MATRIX_SIZE - 1);
    localparam logic [SUB_W-1:0]   LAST_AXIS  = SUB_W'(AXES - 1);

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [MATRIX_SIZE-1:0][VALUE_WIDTH-1:0] row_t;
    typedef logic [AXES-1:0][VALUE_WIDTH-1:0] point_t;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_TEST    = 2'd2
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_X_RD,
        ST_X_CMP,
        ST_X_MUL,
        ST_X_ACC,
        ST_X_SQI,
        ST_X_SQ,
        ST_X_CHK,
        ST_X_DVI,
        ST_X_DV,
        ST_X_DVE,
        ST_X_WR,
        ST_T_START,
        ST_T_RD,
        ST_T_INIT,
        ST_T_MUL,
        ST_T_ACC,
        ST_T_CHK,
        ST_T_DONE
    } state_t;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] row_index;
        row_t       elements;
        point_t     box_min;
        point_t     box_max;
    } in_item_t;

    typedef struct packed {
        logic               load;
        logic               capture;
        logic               mat_rd;
        logic               comp_wr;
        logic               s_clear;
        logic               mul_sq;
        logic               s_add;
        logic               sqrt_init;
        logic               sqrt_step;
        logic               div_init;
        logic               div_step;
        logic               div_store;
        logic               plane_wr;
        logic               pl_rd;
        logic               acc_init;
        logic               mul_box;
        logic               acc_add;
        logic               set_result;
        logic               verdict;
        logic [PLANE_W-1:0] plane;
        logic [SUB_W-1:0]   sub;
    } dp_cmd_t;

    typedef struct packed {
        logic len_zero;
        logic acc_neg;
        logic out_free;
    } dp_stat_t;

endpackage

### design/fbc_if.sv
interface fbc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [1:0]  row_index;
    logic signed [31:0] element_0;
    logic signed [31:0] element_1;
    logic signed [31:0] element_2;
    logic signed [31:0] element_3;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;

    modport source (
        output valid, op, row_index, element_0, element_1, element_2, element_3,
               min_x, min_y, min_z, max_x, max_y, max_z,
        input  ready
    );
    modport sink (
        input  valid, op, row_index, element_0, element_1, element_2, element_3,
               min_x, min_y, min_z, max_x, max_y, max_z,
        output ready
    );
endinterface

interface fbc_out_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, visible, input ready);
    modport sink (input valid, visible, output ready);
endinterface

### design/frustum_box_culling_unit.sv
// Channel   Role    Carries                                   Transfer when
// in_ch     sink    op, row_index, element_0..3, box corners  valid && ready
// out_ch    source  visible                                   valid && ready
// cfg       write   planes_tested (3 bits)                    cfg_wr_en
//
// A load writes its matrix row while idle; a test uses the shared multiplier,
// which forms one product per plane axis.
// An extract runs, per plane, 32 square-root steps and, unless the length is
// zero, four 48-step divisions, one bit each cycle.
// rst_n clears the control state, the plane valid bits and planes_tested (to four).
// A finished result waits in the output register; a test that ends while the
// previous result is still untaken holds until that transfer.
module frustum_box_culling_unit (
    input  logic        clk,
    input  logic        rst_n,
    fbc_in_if.sink      in_ch,
    fbc_out_if.source   out_ch,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data
);

    fbc_pkg::in_item_t item;
    fbc_pkg::dp_cmd_t  cmd;
    fbc_pkg::dp_stat_t stat;

    assign item.op          = in_ch.op;
    assign item.row_index   = in_ch.row_index;
    assign item.elements[0] = in_ch.element_0;
    assign item.elements[1] = in_ch.element_1;
    assign item.elements[2] = in_ch.element_2;
    assign item.elements[3] = in_ch.element_3;
    assign item.box_min[0]  = in_ch.min_x;
    assign item.box_min[1]  = in_ch.min_y;
    assign item.box_min[2]  = in_ch.min_z;
    assign item.box_max[0]  = in_ch.max_x;
    assign item.box_max[1]  = in_ch.max_y;
    assign item.box_max[2]  = in_ch.max_z;

    fbc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_op       (item.op),
        .in_ready    (in_ch.ready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stat        (stat),
        .cmd         (cmd)
    );

    fbc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .cmd         (cmd),
        .stat        (stat),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .out_visible (out_ch.visible)
    );

endmodule

### design/fbc_ctrl.sv
module fbc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [1:0]         in_op,
    output logic               in_ready,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_wr_data,
    input  fbc_pkg::dp_stat_t  stat,
    output fbc_pkg::dp_cmd_t   cmd
);

    fbc_pkg::state_t                   state_reg, state_next;
    logic [fbc_pkg::PLANE_W-1:0]       plane_reg, plane_next;
    logic [fbc_pkg::SUB_W-1:0]         sub_reg, sub_next;
    logic [fbc_pkg::STEP_W-1:0]        step_reg, step_next;
    logic                              verdict_reg, verdict_next;
    logic [2:0]                        cfg_reg;
    logic [fbc_pkg::PLANE_W-1:0]       last_tested;
    logic                              accept;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        if (cfg_reg > 3'(fbc_pkg::PLANE_COUNT))
        begin
            last_tested = fbc_pkg::LAST_PLANE;
        end
        else
        begin
            last_tested = fbc_pkg::PLANE_W'(cfg_reg - 3'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= fbc_pkg::ST_IDLE;
            plane_reg   <= '0;
            sub_reg     <= '0;
            step_reg    <= '0;
            verdict_reg <= 1'b0;
            cfg_reg     <= 3'd4;
        end
        else
        begin
            state_reg   <= state_next;
            plane_reg   <= plane_next;
            sub_reg     <= sub_next;
            step_reg    <= step_next;
            verdict_reg <= verdict_next;
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        plane_next   = plane_reg;
        sub_next     = sub_reg;
        step_next    = step_reg;
        verdict_next = verdict_reg;
        case (state_reg)
            fbc_pkg::ST_IDLE:
            begin
                plane_next = '0;
                sub_next   = '0;
                step_next  = '0;
                if (accept && in_op == fbc_pkg::OP_EXTRACT)
                begin
                    state_next = fbc_pkg::ST_X_RD;
                end
                else if (accept && in_op == fbc_pkg::OP_TEST)
                begin
                    state_next = fbc_pkg::ST_T_START;
                end
            end
            fbc_pkg::ST_X_RD:
            begin
                state_next = fbc_pkg::ST_X_CMP;
            end
            fbc_pkg::ST_X_CMP:
            begin
                if (sub_reg == fbc_pkg::LAST_COMP)
                begin
                    sub_next   = '0;
                    state_next = fbc_pkg::ST_X_MUL;
                end
                else
                begin
                    sub_next   = sub_reg + 1'b1;
                    state_next = fbc_pkg::ST_X_RD;
                end
            end
            fbc_pkg::ST_X_MUL:
            begin
                state_next = fbc_pkg::ST_X_ACC;
            end
            fbc_pkg::ST_X_ACC:
            begin
                if (sub_reg == fbc_pkg::LAST_AXIS)
                begin
                    sub_next   = '0;
                    state_next = fbc_pkg::ST_X_SQI;
                end
                else
                begin
                    sub_next   = sub_reg + 1'b1;
                    state_next = fbc_pkg::ST_X_MUL;
                end
            end
            fbc_pkg::ST_X_SQI:
            begin
                step_next  = '0;
                state_next = fbc_pkg::ST_X_SQ;
            end
            fbc_pkg::ST_X_SQ:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == fbc_pkg::STEP_W'(fbc_pkg::SQRT_STEPS - 1))
                begin
                    state_next = fbc_pkg::ST_X_CHK;
                end
            end
            fbc_pkg::ST_X_CHK:
            begin
                sub_next = '0;
                if (stat.len_zero)
                begin
                    state_next = fbc_pkg::ST_X_WR;
                end
                else
                begin
                    state_next = fbc_pkg::ST_X_DVI;
                end
            end
            fbc_pkg::ST_X_DVI:
            begin
                step_next  = '0;
                state_next = fbc_pkg::ST_X_DV;
            end
            fbc_pkg::ST_X_DV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == fbc_pkg::STEP_W'(fbc_pkg::DIV_STEPS - 1))
                begin
                    state_next = fbc_pkg::ST_X_DVE;
                end
            end
            fbc_pkg::ST_X_DVE:
            begin
                if (sub_reg == fbc_pkg::LAST_COMP)
                begin
                    state_next = fbc_pkg::ST_X_WR;
                end
                else
                begin
                    sub_next   = sub_reg + 1'b1;
                    state_next = fbc_pkg::ST_X_DVI;
                end
            end
            fbc_pkg::ST_X_WR:
            begin
                sub_next = '0;
                if (plane_reg == fbc_pkg::LAST_PLANE)
                begin
                    state_next = fbc_pkg::ST_IDLE;
                end
                else
                begin
                    plane_next = plane_reg + 1'b1;
                    state_next = fbc_pkg::ST_X_RD;
                end
            end
            fbc_pkg::ST_T_START:
            begin
                plane_next = '0;
                if (cfg_reg == 3'd0)
                begin
                    verdict_next = 1'b1;
                    state_next   = fbc_pkg::ST_T_DONE;
                end
                else
                begin
                    state_next = fbc_pkg::ST_T_RD;
                end
            end
            fbc_pkg::ST_T_RD:
            begin
                state_next = fbc_pkg::ST_T_INIT;
            end
            fbc_pkg::ST_T_INIT:
            begin
                sub_next   = '0;
                state_next = fbc_pkg::ST_T_MUL;
            end
            fbc_pkg::ST_T_MUL:
            begin
                state_next = fbc_pkg::ST_T_ACC;
            end
            fbc_pkg::ST_T_ACC:
            begin
                if (sub_reg == fbc_pkg::LAST_AXIS)
                begin
                    state_next = fbc_pkg::ST_T_CHK;
                end
                else
                begin
                    sub_next   = sub_reg + 1'b1;
                    state_next = fbc_pkg::ST_T_MUL;
                end
            end
            fbc_pkg::ST_T_CHK:
            begin
                if (stat.acc_neg)
                begin
                    verdict_next = 1'b0;
                    state_next   = fbc_pkg::ST_T_DONE;
                end
                else if (plane_reg == last_tested)
                begin
                    verdict_next = 1'b1;
                    state_next   = fbc_pkg::ST_T_DONE;
                end
                else
                begin
                    plane_next = plane_reg + 1'b1;
                    state_next = fbc_pkg::ST_T_RD;
                end
            end
            fbc_pkg::ST_T_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = fbc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fbc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.plane   = plane_reg;
        cmd.sub     = sub_reg;
        cmd.verdict = verdict_reg;
        in_ready    = 1'b0;
        case (state_reg)
            fbc_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load    = accept && in_op == fbc_pkg::OP_LOAD;
                cmd.capture = accept && in_op == fbc_pkg::OP_TEST;
            end
            fbc_pkg::ST_X_RD:
            begin
                cmd.mat_rd = 1'b1;
            end
            fbc_pkg::ST_X_CMP:
            begin
                cmd.comp_wr = 1'b1;
                cmd.s_clear = sub_reg == fbc_pkg::LAST_COMP;
            end
            fbc_pkg::ST_X_MUL:
            begin
                cmd.mul_sq = 1'b1;
            end
            fbc_pkg::ST_X_ACC:
            begin
                cmd.s_add = 1'b1;
            end
            fbc_pkg::ST_X_SQI:
            begin
                cmd.sqrt_init = 1'b1;
            end
            fbc_pkg::ST_X_SQ:
            begin
                cmd.sqrt_step = 1'b1;
            end
            fbc_pkg::ST_X_DVI:
            begin
                cmd.div_init = 1'b1;
            end
            fbc_pkg::ST_X_DV:
            begin
                cmd.div_step = 1'b1;
            end
            fbc_pkg::ST_X_DVE:
            begin
                cmd.div_store = 1'b1;
            end
            fbc_pkg::ST_X_WR:
            begin
                cmd.plane_wr = 1'b1;
            end
            fbc_pkg::ST_T_RD:
            begin
                cmd.pl_rd = 1'b1;
            end
            fbc_pkg::ST_T_INIT:
            begin
                cmd.acc_init = 1'b1;
            end
            fbc_pkg::ST_T_MUL:
            begin
                cmd.mul_box = 1'b1;
            end
            fbc_pkg::ST_T_ACC:
            begin
                cmd.acc_add = 1'b1;
            end
            fbc_pkg::ST_T_DONE:
            begin
                cmd.set_result = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    a_load_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_op == fbc_pkg::OP_LOAD) |=> state_reg == fbc_pkg::ST_IDLE)
        else $error("load transfer did not return to idle");

    a_result_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_result |-> stat.out_free)
        else $error("result written while output register is occupied");

    a_plane_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        plane_reg <= fbc_pkg::LAST_PLANE)
        else $error("plane counter out of range");

    a_cull_reported: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fbc_pkg::ST_T_CHK && stat.acc_neg)
        |=> (state_reg == fbc_pkg::ST_T_DONE && !verdict_reg))
        else $error("negative plane distance did not cull the box");

endmodule

### design/fbc_datapath.sv
module fbc_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  fbc_pkg::in_item_t  item,
    input  fbc_pkg::dp_cmd_t   cmd,
    output fbc_pkg::dp_stat_t  stat,
    input  logic               out_ready,
    output logic               out_valid,
    output logic               out_visible
);

    fbc_pkg::row_t mat_mem [fbc_pkg::MATRIX_SIZE];
    fbc_pkg::row_t pl_mem  [fbc_pkg::PLANE_COUNT];
    fbc_pkg::row_t mat_rd_reg;
    fbc_pkg::row_t pl_rd_reg;
    fbc_pkg::row_t comp_reg;
    logic [fbc_pkg::PLANE_COUNT-1:0] pl_vld_reg;
    logic                            pl_rd_ok_reg;
    fbc_pkg::point_t box_min_reg, box_max_reg;

    logic signed [fbc_pkg::PROD_W-1:0]  mul_reg;
    logic [fbc_pkg::SUMSQ_W-1:0]        s_reg;
    logic signed [fbc_pkg::ACC_W-1:0]   acc_reg;
    logic [fbc_pkg::SUMSQ_W-1:0]        sq_src_reg;
    logic [fbc_pkg::REM_W-1:0]          sq_rem_reg;
    logic [fbc_pkg::LEN_W-1:0]          sq_res_reg;
    logic [fbc_pkg::NUM_W-1:0]          dv_num_reg;
    logic [fbc_pkg::LEN_W:0]            dv_rem_reg;
    logic [fbc_pkg::NUM_W-1:0]          dv_q_reg;
    logic                               dv_neg_reg;
    logic                               out_valid_reg, out_visible_reg;

    logic signed [fbc_pkg::VALUE_WIDTH-1:0] w_val, e_val, n_val, d_val, x_val;
    logic signed [fbc_pkg::VALUE_WIDTH-1:0] lo_val, hi_val;
    logic signed [fbc_pkg::OPND_W-1:0]      comb_sum, c2_val, op_a, op_b;
    fbc_pkg::value_t                        comp_sat, q_sat, x_mag;
    fbc_pkg::row_t                          plane_eff;
    logic [fbc_pkg::NUM_W-1:0]              num_init;
    logic [fbc_pkg::REM_W-1:0]              sq_trial, sq_rt;
    logic [fbc_pkg::LEN_W:0]                dv_rt, len_ext;
    logic                                   sq_ge, dv_ge;

    assign plane_eff = pl_rd_ok_reg ? pl_rd_reg : '0;

    always_comb
    begin
        w_val = $signed(mat_rd_reg[fbc_pkg::MATRIX_SIZE-1]);
        e_val = $signed(mat_rd_reg[cmd.plane[fbc_pkg::PLANE_W-1:1]]);
        if (cmd.plane[0])
        begin
            comb_sum = {w_val[fbc_pkg::VALUE_WIDTH-1], w_val}
                     - {e_val[fbc_pkg::VALUE_WIDTH-1], e_val};
        end
        else
        begin
            comb_sum = {w_val[fbc_pkg::VALUE_WIDTH-1], w_val}
                     + {e_val[fbc_pkg::VALUE_WIDTH-1], e_val};
        end
        if (comb_sum[fbc_pkg::OPND_W-1] != comb_sum[fbc_pkg::OPND_W-2])
        begin
            comp_sat = comb_sum[fbc_pkg::OPND_W-1]
                     ? {1'b1, {(fbc_pkg::VALUE_WIDTH-1){1'b0}}}
                     : {1'b0, {(fbc_pkg::VALUE_WIDTH-1){1'b1}}};
        end
        else
        begin
            comp_sat = comb_sum[fbc_pkg::VALUE_WIDTH-1:0];
        end
    end

    always_comb
    begin
        n_val  = $signed(plane_eff[cmd.sub]);
        d_val  = $signed(plane_eff[fbc_pkg::MATRIX_SIZE-1]);
        lo_val = $signed(box_min_reg[cmd.sub[1:0]]);
        hi_val = $signed(box_max_reg[cmd.sub[1:0]]);
        if (n_val > 0)
        begin
            c2_val = {hi_val, 1'b0};
        end
        else if (n_val < 0)
        begin
            c2_val = {lo_val, 1'b0};
        end
        else
        begin
            c2_val = {lo_val[fbc_pkg::VALUE_WIDTH-1], lo_val}
                   + {hi_val[fbc_pkg::VALUE_WIDTH-1], hi_val};
        end
        x_val = $signed(comp_reg[cmd.sub]);
        if (cmd.mul_box)
        begin
            op_a = c2_val;
            op_b = {n_val[fbc_pkg::VALUE_WIDTH-1], n_val};
        end
        else
        begin
            op_a = {x_val[fbc_pkg::VALUE_WIDTH-1], x_val};
            op_b = {x_val[fbc_pkg::VALUE_WIDTH-1], x_val};
        end
    end

    always_comb
    begin
        x_mag    = x_val[fbc_pkg::VALUE_WIDTH-1] ? (~comp_reg[cmd.sub] + 1'b1)
                                                 : comp_reg[cmd.sub];
        num_init = {x_mag, {fbc_pkg::FRACTION_BITS{1'b0}}}
                 + fbc_pkg::NUM_W'(sq_res_reg[fbc_pkg::LEN_W-1:1]);
        sq_rt    = {sq_rem_reg[fbc_pkg::REM_W-3:0],
                    sq_src_reg[fbc_pkg::SUMSQ_W-1:fbc_pkg::SUMSQ_W-2]};
        sq_trial = {1'b0, sq_res_reg, 2'b01};
        sq_ge    = sq_rt >= sq_trial;
        len_ext  = {1'b0, sq_res_reg};
        dv_rt    = {dv_rem_reg[fbc_pkg::LEN_W-1:0], dv_num_reg[fbc_pkg::NUM_W-1]};
        dv_ge    = dv_rt >= len_ext;
        if (dv_neg_reg)
        begin
            if (dv_q_reg > fbc_pkg::NUM_W'({1'b1, {(fbc_pkg::VALUE_WIDTH-1){1'b0}}}))
            begin
                q_sat = {1'b1, {(fbc_pkg::VALUE_WIDTH-1){1'b0}}};
            end
            else
            begin
                q_sat = ~dv_q_reg[fbc_pkg::VALUE_WIDTH-1:0] + 1'b1;
            end
        end
        else
        begin
            if (dv_q_reg > fbc_pkg::NUM_W'({1'b0, {(fbc_pkg::VALUE_WIDTH-1){1'b1}}}))
            begin
                q_sat = {1'b0, {(fbc_pkg::VALUE_WIDTH-1){1'b1}}};
            end
            else
            begin
                q_sat = dv_q_reg[fbc_pkg::VALUE_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mat_mem[item.row_index] <= item.elements;
        end
        if (cmd.mat_rd)
        begin
            mat_rd_reg <= mat_mem[cmd.sub];
        end
        if (cmd.plane_wr)
        begin
            pl_mem[cmd.plane] <= comp_reg;
        end
        if (cmd.pl_rd)
        begin
            pl_rd_reg <= pl_mem[cmd.plane];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            box_min_reg <= item.box_min;
            box_max_reg <= item.box_max;
        end
        if (cmd.comp_wr)
        begin
            comp_reg[cmd.sub] <= comp_sat;
        end
        else if (cmd.div_store)
        begin
            comp_reg[cmd.sub] <= q_sat;
        end
        if (cmd.mul_sq || cmd.mul_box)
        begin
            mul_reg <= op_a * op_b;
        end
        if (cmd.s_clear)
        begin
            s_reg <= '0;
        end
        else if (cmd.s_add)
        begin
            s_reg <= s_reg + mul_reg[fbc_pkg::SUMSQ_W-1:0];
        end
        if (cmd.acc_init)
        begin
            acc_reg <= {{(fbc_pkg::ACC_W-fbc_pkg::VALUE_WIDTH-fbc_pkg::FRACTION_BITS-1)
                         {d_val[fbc_pkg::VALUE_WIDTH-1]}},
                        d_val, {(fbc_pkg::FRACTION_BITS+1){1'b0}}};
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + {{(fbc_pkg::ACC_W-fbc_pkg::PROD_W){mul_reg[fbc_pkg::PROD_W-1]}},
                                  mul_reg};
        end
        if (cmd.sqrt_init)
        begin
            sq_src_reg <= s_reg;
            sq_rem_reg <= '0;
            sq_res_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            sq_src_reg <= {sq_src_reg[fbc_pkg::SUMSQ_W-3:0], 2'b00};
            sq_rem_reg <= sq_ge ? (sq_rt - sq_trial) : sq_rt;
            sq_res_reg <= {sq_res_reg[fbc_pkg::LEN_W-2:0], sq_ge};
        end
        if (cmd.div_init)
        begin
            dv_num_reg <= num_init;
            dv_rem_reg <= '0;
            dv_q_reg   <= '0;
            dv_neg_reg <= x_val[fbc_pkg::VALUE_WIDTH-1];
        end
        else if (cmd.div_step)
        begin
            dv_num_reg <= {dv_num_reg[fbc_pkg::NUM_W-2:0], 1'b0};
            dv_rem_reg <= dv_ge ? (dv_rt - len_ext) : dv_rt;
            dv_q_reg   <= {dv_q_reg[fbc_pkg::NUM_W-2:0], dv_ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pl_vld_reg      <= '0;
            pl_rd_ok_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_visible_reg <= 1'b0;
        end
        else
        begin
            if (cmd.plane_wr)
            begin
                pl_vld_reg[cmd.plane] <= 1'b1;
            end
            if (cmd.pl_rd)
            begin
                pl_rd_ok_reg <= pl_vld_reg[cmd.plane];
            end
            if (cmd.set_result)
            begin
                out_valid_reg   <= 1'b1;
                out_visible_reg <= cmd.verdict;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.len_zero = sq_res_reg == '0;
    assign stat.acc_neg  = acc_reg[fbc_pkg::ACC_W-1];
    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_visible   = out_visible_reg;

endmodule

### dv/tb_frustum_box_culling_unit.sv
module tb_frustum_box_culling_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int EXTRACT_WAIT = 2000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh80000000;
    localparam logic signed [31:0] ONE_Q = 32'sh00010000;

    typedef struct {
        logic [1:0]         op;
        logic [1:0]         row;
        logic signed [31:0] elem[4];
        logic signed [31:0] lo[3];
        logic signed [31:0] hi[3];
    } cull_item_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [2:0] cfg_wr_data;

    fbc_in_if in_ch();
    fbc_out_if out_ch();

    frustum_box_culling_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    cull_item_t pending_items[$];
    logic expected_visible[$];
    logic signed [31:0] matrix_q[16];
    logic signed [31:0] plane_q[24];
    logic [2:0] planes_tested_q;
    int errors;
    int cycles;
    int tests_sent;
    int send_gap;
    int recv_gap;
    int hold_cycles;
    bit hold_done;
    bit quiet;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] x);
        if (x > 128'(VAL_MAX))
            return VAL_MAX;
        if (x < 128'(VAL_MIN))
            return VAL_MIN;
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] normalize(input logic signed [31:0] x,
                                                     input logic signed [127:0] len);
        logic signed [127:0] m;
        logic signed [127:0] q;
        begin
            m = x;
            if (m < 0)
                m = -m;
            q = ((m <<< fbc_pkg::FRACTION_BITS) + (len >>> 1)) / len;
            if (x < 0)
                return (q > 128'sd2147483648) ? VAL_MIN : clamp32(-q);
            return (q > 128'(VAL_MAX)) ? VAL_MAX : q[31:0];
        end
    endfunction

    task automatic extract_planes();
        logic signed [127:0] w;
        logic signed [127:0] e;
        logic signed [127:0] sq;
        logic signed [127:0] len;
        logic signed [127:0] cand;
        int k;
        begin
            for (int p = 0; p < fbc_pkg::PLANE_COUNT; p++)
            begin
                k = p / 2;
                sq = 0;
                for (int j = 0; j < 4; j++)
                begin
                    w = matrix_q[4 * j + 3];
                    e = matrix_q[4 * j + k];
                    plane_q[4 * p + j] = clamp32((p % 2 == 1) ? w - e : w + e);
                end
                for (int j = 0; j < 3; j++)
                begin
                    w = plane_q[4 * p + j];
                    sq += w * w;
                end
                len = 0;
                for (int b = 33; b >= 0; b--)
                begin
                    cand = len | (128'sd1 <<< b);
                    if (cand * cand <= sq)
                        len = cand;
                end
                if (len != 0)
                begin
                    for (int j = 0; j < 4; j++)
                        plane_q[4 * p + j] = normalize(plane_q[4 * p + j], len);
                end
            end
        end
    endtask

    function automatic logic box_visible(input cull_item_t it);
        logic signed [127:0] acc;
        logic signed [127:0] n;
        logic signed [127:0] c2;
        int count;
        begin
            count = (planes_tested_q > fbc_pkg::PLANE_COUNT) ? fbc_pkg::PLANE_COUNT
                                                              : planes_tested_q;
            for (int p = 0; p < count; p++)
            begin
                n = plane_q[4 * p + 3];
                acc = n <<< (fbc_pkg::FRACTION_BITS + 1);
                for (int a = 0; a < 3; a++)
                begin
                    n = plane_q[4 * p + a];
                    if (n > 0)
                        c2 = 128'(it.hi[a]) * 2;
                    else if (n < 0)
                        c2 = 128'(it.lo[a]) * 2;
                    else
                        c2 = 128'(it.lo[a]) + 128'(it.hi[a]);
                    acc += c2 * n;
                end
                if (acc < 0)
                    return 1'b0;
            end
            return 1'b1;
        end
    endfunction

    task automatic apply_item(input cull_item_t it);
        begin
            case (it.op)
                fbc_pkg::OP_LOAD:
                    for (int k = 0; k < 4; k++)
                        matrix_q[4 * it.row + k] = it.elem[k];
                fbc_pkg::OP_EXTRACT:
                    extract_planes();
                fbc_pkg::OP_TEST:
                begin
                    expected_visible.push_back(box_visible(it));
                    tests_sent++;
                end
                default:
                    ;
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cull_item_t it;
        cull_item_t sent;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                sent.op = in_ch.op;
                sent.row = in_ch.row_index;
                sent.elem[0] = in_ch.element_0;
                sent.elem[1] = in_ch.element_1;
                sent.elem[2] = in_ch.element_2;
                sent.elem[3] = in_ch.element_3;
                sent.lo[0] = in_ch.min_x;
                sent.lo[1] = in_ch.min_y;
                sent.lo[2] = in_ch.min_z;
                sent.hi[0] = in_ch.max_x;
                sent.hi[1] = in_ch.max_y;
                sent.hi[2] = in_ch.max_z;
                apply_item(sent);
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    it = pending_items.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.op <= it.op;
                    in_ch.row_index <= it.row;
                    in_ch.element_0 <= it.elem[0];
                    in_ch.element_1 <= it.elem[1];
                    in_ch.element_2 <= it.elem[2];
                    in_ch.element_3 <= it.elem[3];
                    in_ch.min_x <= it.lo[0];
                    in_ch.min_y <= it.lo[1];
                    in_ch.min_z <= it.lo[2];
                    in_ch.max_x <= it.hi[0];
                    in_ch.max_y <= it.hi[1];
                    in_ch.max_z <= it.hi[2];
                    if (!quiet && $urandom_range(0, 7) == 0)
                        send_gap <= $urandom_range(1, 4);
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // The one long receiver stall lets the block fill up and back-pressure its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            recv_gap <= 0;
            hold_cycles <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && tests_sent >= 300)
        begin
            hold_done <= 1'b1;
            hold_cycles <= 400;
            out_ch.ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            out_ch.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            recv_gap <= $urandom_range(0, 3);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        logic want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_visible.size() == 0)
                report_mismatch($sformatf("unexpected result visible=%0b", out_ch.visible));
            else
            begin
                want = expected_visible.pop_front();
                if (out_ch.visible !== want)
                    report_mismatch($sformatf("visible=%0b, expected %0b",
                                              out_ch.visible, want));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 9))
            0:
                case ($urandom_range(0, 4))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return 32'sd0;
                    3: return -32'sd1;
                    default: return ONE_Q;
                endcase
            1, 2: return $urandom;
            default: return $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
        endcase
    endfunction

    function automatic cull_item_t make_item(input logic [1:0] op);
        cull_item_t it;
        logic signed [31:0] c;
        logic signed [31:0] h;
        begin
            it.op = op;
            it.row = $urandom_range(0, 3);
            for (int k = 0; k < 4; k++)
                it.elem[k] = $urandom;
            for (int a = 0; a < 3; a++)
            begin
                it.lo[a] = $urandom;
                it.hi[a] = $urandom;
            end
            if (op == fbc_pkg::OP_LOAD)
            begin
                for (int k = 0; k < 4; k++)
                    it.elem[k] = rand_value();
            end
            else if (op == fbc_pkg::OP_TEST && $urandom_range(0, 9) != 0)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    c = $signed($urandom_range(0, 32'h001FFFFF)) - 32'sh00100000;
                    h = $urandom_range(0, 32'h0003FFFF);
                    it.lo[a] = c - h;
                    it.hi[a] = c + h;
                    if ($urandom_range(0, 19) == 0)
                    begin
                        it.lo[a] = c + h;
                        it.hi[a] = c - h;
                    end
                end
            end
            return it;
        end
    endfunction

    task automatic queue_matrix_load();
        for (int r = 0; r < 4; r++)
        begin
            cull_item_t it;
            it = make_item(fbc_pkg::OP_LOAD);
            it.row = r;
            pending_items.push_back(it);
        end
        pending_items.push_back(make_item(fbc_pkg::OP_EXTRACT));
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || in_ch.valid || expected_visible.size() > 0)
            @(posedge clk);
        repeat (EXTRACT_WAIT) @(posedge clk);
    endtask

    task automatic write_planes_tested(input logic [2:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        planes_tested_q = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        cull_item_t it;
        logic [2:0] phase_cfg[8];
        int r;
        errors = 0;
        cycles = 0;
        tests_sent = 0;
        quiet = 1'b0;
        planes_tested_q = 3'd4;
        foreach (matrix_q[i])
            matrix_q[i] = 32'sd0;
        foreach (plane_q[i])
            plane_q[i] = 32'sd0;
        phase_cfg = '{3'd4, 3'd1, 3'd6, 3'd0, 3'd7, 3'd3, 3'd5, 3'd2};
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 3'd0;
        in_ch.valid = 1'b0;
        in_ch.op = fbc_pkg::OP_LOAD;
        in_ch.row_index = 2'd0;
        in_ch.element_0 = 0;
        in_ch.element_1 = 0;
        in_ch.element_2 = 0;
        in_ch.element_3 = 0;
        in_ch.min_x = 0;
        in_ch.min_y = 0;
        in_ch.min_z = 0;
        in_ch.max_x = 0;
        in_ch.max_y = 0;
        in_ch.max_z = 0;
        out_ch.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: planes still all zero, a zero matrix, saturated planes, odd boxes.
        pending_items.push_back(make_item(fbc_pkg::OP_TEST));
        for (r = 0; r < 4; r++)
        begin
            it = make_item(fbc_pkg::OP_LOAD);
            it.row = r;
            it.elem = '{0, 0, 0, 0};
            pending_items.push_back(it);
        end
        pending_items.push_back(make_item(fbc_pkg::OP_EXTRACT));
        pending_items.push_back(make_item(fbc_pkg::OP_TEST));
        for (r = 0; r < 4; r++)
        begin
            it = make_item(fbc_pkg::OP_LOAD);
            it.row = r;
            if (r % 2 == 0)
                it.elem = '{VAL_MAX, VAL_MIN, VAL_MAX, VAL_MAX};
            else
                it.elem = '{VAL_MIN, VAL_MAX, VAL_MIN, VAL_MIN};
            pending_items.push_back(it);
        end
        pending_items.push_back(make_item(fbc_pkg::OP_EXTRACT));
        it = make_item(fbc_pkg::OP_TEST);
        it.lo = '{VAL_MIN, VAL_MIN, VAL_MIN};
        it.hi = '{VAL_MAX, VAL_MAX, VAL_MAX};
        pending_items.push_back(it);
        it.lo = '{VAL_MAX, VAL_MAX, VAL_MAX};
        it.hi = '{VAL_MIN, VAL_MIN, VAL_MIN};
        pending_items.push_back(it);
        for (r = 0; r < 4; r++)
        begin
            it = make_item(fbc_pkg::OP_LOAD);
            it.row = r;
            it.elem = '{0, 0, 0, 0};
            it.elem[r] = ONE_Q;
            if (r == 3)
                it.elem = '{0, 0, 0, ONE_Q};
            pending_items.push_back(it);
        end
        pending_items.push_back(make_item(fbc_pkg::OP_EXTRACT));
        it = make_item(fbc_pkg::OP_TEST);
        it.lo = '{0, 0, 0};
        it.hi = '{0, 0, 0};
        pending_items.push_back(it);
        pending_items.push_back(make_item(OP_UNUSED));
        pending_items.push_back(make_item(fbc_pkg::OP_TEST));
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 7)
                quiet = 1'b1;
            if (ph > 0)
                write_planes_tested(phase_cfg[ph]);
            for (int n = 0; n < 165; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    queue_matrix_load();
                else if (r < 4)
                    pending_items.push_back(make_item(fbc_pkg::OP_LOAD));
                else if (r < 5)
                    pending_items.push_back(make_item(fbc_pkg::OP_EXTRACT));
                else if (r < 7)
                    pending_items.push_back(make_item(OP_UNUSED));
                else
                    pending_items.push_back(make_item(fbc_pkg::OP_TEST));
            end
            drain();
        end

        if (expected_visible.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_visible.size()));
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

### sim.f
design/fbc_pkg.sv
design/fbc_if.sv
design/fbc_ctrl.sv
design/fbc_datapath.sv
design/frustum_box_culling_unit.sv
dv/tb_frustum_box_culling_unit.sv
